### rtl/fpst_pkg.sv
// Shared types and constants of the Fenwick prefix-sum table.
`default_nettype none

package fpst_pkg;

  // Width of the index walker; holds any position plus one lowest-bit step.
  localparam int unsigned WALK_W = 12;
  localparam int unsigned POS_W  = 11;
  localparam int unsigned SIZE_W = 11;
  localparam int unsigned OUT_W  = 32;
  localparam int unsigned ADD_W  = 32;

  typedef enum logic [1:0] {
    CMD_QUERY = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QRD,
    ST_QACC,
    ST_ARD,
    ST_AWR
  } state_e;

  // Controls for the shared arithmetic unit.
  typedef struct packed {
    logic walk_up;  // step the index up (add) or down (query)
    logic acc_sel;  // add the read cell to the running sum, else to the amount
  } unit_ctl_t;

endpackage

`default_nettype wire

### rtl/fenwick_prefix_sum_table.sv
// Top level of the Fenwick prefix-sum table: sequencer, registers and cell memory.
//
// A binary indexed tree of TABLE_SIZE signed cells, indexed from 1, kept in one
// RAM with a registered read port. A request carries a command: a prefix query
// returns one result, the wrapping sum of the values at indices 1 to position;
// a point add adds add_value to every cell on the upward walk from position up
// to min(size_in_use, TABLE_SIZE); a clear zeroes the whole table. Add and clear
// return no result, and command code 3 is dropped. Every visited cell takes a
// read on the RAM read port, then an accumulate or write back in the shared
// adder, while a query step at an index above the table only steps the index
// down. A query keeps in_stall_o high until its walk reaches index zero and it
// has handed off its result; an add keeps it high until its walk passes the
// limit or starts at index zero. An add at index 1 visits 11 cells when 1024
// cells are in use. A query also waits for as long as the output register is
// still stalled. A clear sweeps the RAM one cell a cycle, and the same clearing
// pass runs after reset; no request is taken while it runs. One request is
// worked on at a time, and in_stall_o is high until it is done. A finished
// query result waits in an output register, so the next request is accepted
// while the result is still stalled. size_in_use may be written only while the
// block is idle.
`default_nettype none

module fenwick_prefix_sum_table
  import fpst_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = 1024,
  parameter int unsigned CELL_WIDTH = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,

  input  wire logic                    cfg_we_i,
  input  wire logic [SIZE_W-1:0]       cfg_wdata_i,

  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [1:0]              cmd_i,
  input  wire logic [POS_W-1:0]        position_i,
  input  wire logic signed [ADD_W-1:0] add_value_i,

  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic signed [OUT_W-1:0]      prefix_sum_o
);

  localparam int unsigned AW = $clog2(TABLE_SIZE);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_SIZE - 1);

  state_e state_q, state_d;

  logic [WALK_W-1:0]     pos_q, pos_d;
  logic [WALK_W-1:0]     limit_q, limit_d;
  logic [CELL_WIDTH-1:0] acc_q, acc_d;
  logic [CELL_WIDTH-1:0] amount_q, amount_d;
  logic [AW-1:0]         clr_addr_q, clr_addr_d;
  logic [SIZE_W-1:0]     size_q;
  logic                  out_valid_q, out_valid_d;
  logic [OUT_W-1:0]      out_data_q, out_data_d;

  logic                  in_accept;
  logic                  out_free;
  logic                  pos_in_table;
  logic                  pos_in_limit;
  logic [WALK_W-1:0]     limit_in;
  logic [WALK_W-1:0]     pos_m1;
  logic [WALK_W+AW-1:0]  pos_m1_ext;
  logic [AW-1:0]         cell_addr;
  logic [CELL_WIDTH+ADD_W-1:0] amount_ext;
  logic [OUT_W+CELL_WIDTH-1:0] acc_ext;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [CELL_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [CELL_WIDTH-1:0] ram_rdata;

  unit_ctl_t             unit_ctl;
  logic [WALK_W-1:0]     unit_pos_next;
  logic [CELL_WIDTH-1:0] unit_sum;

  fpst_ram #(
    .WIDTH (CELL_WIDTH),
    .DEPTH (TABLE_SIZE)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  fpst_unit #(
    .CELL_W (CELL_WIDTH)
  ) u_unit (
    .ctl_i      (unit_ctl),
    .pos_i      (pos_q),
    .acc_i      (acc_q),
    .amount_i   (amount_q),
    .cell_i     (ram_rdata),
    .pos_next_o (unit_pos_next),
    .sum_o      (unit_sum)
  );

  // Handshake and derived values.
  always_comb begin
    in_stall_o   = (state_q != ST_IDLE);
    in_accept    = in_valid_i && !in_stall_o;
    out_free     = !out_valid_q || !out_stall_i;
    pos_in_table = (32'(pos_q) <= 32'(TABLE_SIZE));
    pos_in_limit = (pos_q <= limit_q);
    // Adds never propagate past the physical table.
    if (32'(size_q) > 32'(TABLE_SIZE)) begin
      limit_in = WALK_W'(TABLE_SIZE);
    end else begin
      limit_in = WALK_W'(size_q);
    end
    pos_m1     = pos_q - 1'b1;
    pos_m1_ext = {{AW{1'b0}}, pos_m1};
    cell_addr  = pos_m1_ext[AW-1:0];
    amount_ext = {{CELL_WIDTH{add_value_i[ADD_W-1]}}, add_value_i};
    acc_ext    = {{OUT_W{1'b0}}, acc_q};
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_addr_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          unique case (cmd_i)
            CMD_QUERY: state_d = ST_QRD;
            CMD_ADD:   state_d = ST_ARD;
            CMD_CLEAR: state_d = ST_CLEAR;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_QRD: begin
        priority if (pos_q == '0) begin
          if (out_free) begin
            state_d = ST_IDLE;
          end
        end else if (pos_in_table) begin
          state_d = ST_QACC;
        end else begin
          state_d = ST_QRD;
        end
      end
      ST_QACC: state_d = ST_QRD;
      ST_ARD: begin
        if (pos_q == '0 || !pos_in_limit) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_AWR;
        end
      end
      ST_AWR: state_d = ST_ARD;
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    pos_d       = pos_q;
    limit_d     = limit_q;
    acc_d       = acc_q;
    amount_d    = amount_q;
    clr_addr_d  = clr_addr_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_we      = 1'b0;
    ram_waddr   = cell_addr;
    ram_wdata   = unit_sum;
    ram_raddr   = cell_addr;
    unit_ctl    = '{walk_up: 1'b0, acc_sel: 1'b1};
    unique case (state_q)
      ST_CLEAR: begin
        ram_we     = 1'b1;
        ram_waddr  = clr_addr_q;
        ram_wdata  = '0;
        clr_addr_d = clr_addr_q + 1'b1;
      end
      ST_IDLE: begin
        if (in_accept) begin
          pos_d      = {1'b0, position_i};
          acc_d      = '0;
          amount_d   = amount_ext[CELL_WIDTH-1:0];
          limit_d    = limit_in;
          clr_addr_d = '0;
        end
      end
      ST_QRD: begin
        if (pos_q == '0) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_data_d  = acc_ext[OUT_W-1:0];
          end
        end else if (!pos_in_table) begin
          // Cells beyond the table read as zero: just step down.
          pos_d = unit_pos_next;
        end
      end
      ST_QACC: begin
        acc_d = unit_sum;
        pos_d = unit_pos_next;
      end
      ST_ARD: begin
        unit_ctl = '{walk_up: 1'b1, acc_sel: 1'b0};
      end
      ST_AWR: begin
        unit_ctl = '{walk_up: 1'b1, acc_sel: 1'b0};
        ram_we   = 1'b1;
        pos_d    = unit_pos_next;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
      size_q      <= SIZE_W'(1024);
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    limit_q    <= limit_d;
    acc_q      <= acc_d;
    amount_q   <= amount_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o  = out_valid_q;
  assign prefix_sum_o = out_data_q;

endmodule

`default_nettype wire

### rtl/fpst_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none

module fpst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/fpst_unit.sv
// Shared cell adder and lowest-set-bit index stepper.
`default_nettype none

module fpst_unit
  import fpst_pkg::*;
#(
  parameter int unsigned CELL_W = 32
) (
  input  wire unit_ctl_t           ctl_i,
  input  wire logic [WALK_W-1:0]   pos_i,
  input  wire logic [CELL_W-1:0]   acc_i,
  input  wire logic [CELL_W-1:0]   amount_i,
  input  wire logic [CELL_W-1:0]   cell_i,
  output logic      [WALK_W-1:0]   pos_next_o,
  output logic      [CELL_W-1:0]   sum_o
);

  logic [WALK_W-1:0] low_bit;

  always_comb begin
    low_bit = pos_i & (~pos_i + 1'b1);
    if (ctl_i.walk_up) begin
      pos_next_o = pos_i + low_bit;
    end else begin
      pos_next_o = pos_i - low_bit;
    end
    sum_o = (ctl_i.acc_sel ? acc_i : amount_i) + cell_i;
  end

endmodule

`default_nettype wire

### dv/tb_fenwick_prefix_sum_table.sv
// Self-checking testbench of the Fenwick prefix-sum table with its own tree predictor.
`default_nettype none

module tb_fenwick_prefix_sum_table
  import fpst_pkg::*;
();

  // Matches the default geometry of the block.
  localparam int unsigned TREE_CELLS = 1024;
  // Command code 3 has no meaning and must be dropped by the block.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // A clear sweeps every cell once, so this covers the slowest request in flight.
  localparam int unsigned SETTLE_CYCLES = 1100;
  localparam int unsigned CYCLE_LIMIT = 500000;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [SIZE_W-1:0] cfg_wdata_i;
  logic in_valid_i;
  logic in_stall_o;
  logic [1:0] cmd_i;
  logic [POS_W-1:0] position_i;
  logic signed [ADD_W-1:0] add_value_i;
  logic out_valid_o;
  logic out_stall_i;
  logic signed [OUT_W-1:0] prefix_sum_o;

  // Predicted contents of the tree and the size register.
  logic [31:0] tree_cells [TREE_CELLS];
  logic [SIZE_W-1:0] size_reg;
  // Prefix sums still owed by the block, oldest first.
  logic signed [31:0] pending_sums [$];

  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  // Random idling of both sides; cleared for the burst and the hold-off phases.
  bit idle_on = 1'b1;
  // Cycles for which the receiver still holds off every result.
  int unsigned hold_left = 0;

  fenwick_prefix_sum_table DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .position_i   (position_i),
    .add_value_i  (add_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .prefix_sum_o (prefix_sum_o)
  );

  always #2 clk_i = ~clk_i;

  // Sum of the cells on the downward walk; indices beyond the table read as zero.
  function automatic logic [31:0] tree_prefix_sum(int unsigned pos);
    logic [31:0] acc;
    int unsigned p;
    acc = '0;
    p = pos;
    while (p != 0) begin
      if (p <= TREE_CELLS) acc = acc + tree_cells[p-1];
      p = p - (p & (~p + 1));
    end
    return acc;
  endfunction

  // Upward walk that stops at the size in use, itself capped at the table size.
  function automatic void tree_point_add(int unsigned pos, logic [31:0] amount);
    int unsigned p;
    int unsigned lim;
    lim = (size_reg > TREE_CELLS) ? TREE_CELLS : size_reg;
    if (pos == 0) return;
    p = pos;
    while (p <= lim) begin
      tree_cells[p-1] = tree_cells[p-1] + amount;
      p = p + (p & (~p + 1));
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_cnt, msg);
    mismatch_cnt++;
  endtask

  // Everything is judged at the rising edge on values that were settled before it.
  always @(posedge clk_i) begin
    logic signed [31:0] want;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d sums pending", cycle_cnt, pending_sums.size());
      $display("RESULT: ERROR");
      $finish;
    end else if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_sums.size() == 0) begin
          report_mismatch($sformatf("unexpected prefix_sum %h", prefix_sum_o));
        end else begin
          want = pending_sums.pop_front();
          if (prefix_sum_o !== want)
            report_mismatch($sformatf("prefix_sum %h, predicted %h", prefix_sum_o, want));
        end
      end
      if (cfg_we_i) size_reg = cfg_wdata_i;
      if (in_valid_i && !in_stall_o) begin
        case (cmd_i)
          CMD_QUERY: pending_sums.insert(pending_sums.size(), tree_prefix_sum(position_i));
          CMD_ADD:   tree_point_add(position_i, add_value_i);
          CMD_CLEAR: foreach (tree_cells[i]) tree_cells[i] = '0;
          default: ;
        endcase
      end
    end
  end

  // Receiver: a pending hold-off wins, otherwise stall at random when idling is on.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall_i <= idle_on && ($urandom_range(99) < 33);
    end
  end

  // Offers one request and returns at the edge that accepts it. Valid stays high
  // afterwards, so back-to-back calls with idling off move straight on to the next payload.
  task automatic send_request(input logic [1:0] c, input logic [POS_W-1:0] p,
                              input logic [31:0] v);
    while (idle_on && $urandom_range(99) < 33) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    cmd_i       <= c;
    position_i  <= p;
    add_value_i <= v;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Waits for every owed sum, then lets any add or clear still running finish.
  task automatic drain_and_settle();
    stop_sending();
    while (pending_sums.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly queries and adds inside the size in use, so the tree fills up and
  // the sums mean something; the rest reaches the edges of every field.
  task automatic rand_request(output logic [1:0] c, output logic [POS_W-1:0] p,
                              output logic [31:0] v);
    int unsigned roll;
    int unsigned lim;
    roll = $urandom_range(99);
    if (roll < 45) c = CMD_QUERY;
    else if (roll < 95) c = CMD_ADD;
    else if (roll < 97) c = CMD_CLEAR;
    else c = CMD_UNUSED;
    lim = (size_reg == 0 || size_reg > TREE_CELLS) ? TREE_CELLS : size_reg;
    roll = $urandom_range(99);
    if (roll < 55) p = POS_W'($urandom_range(lim, 1));
    else if (roll < 75) p = POS_W'($urandom_range(2047, 0));
    else if (roll < 90) p = POS_W'($urandom_range(16, 0));
    else p = POS_W'(lim);
    roll = $urandom_range(99);
    if (roll < 80) v = $urandom();
    else if (roll < 90) v = 32'($urandom_range(20, 0)) - 32'd10;
    else if (roll < 95) v = 32'h8000_0000;
    else v = 32'h7fff_ffff;
  endtask

  task automatic test_random_traffic(input int unsigned count);
    logic [1:0] c;
    logic [POS_W-1:0] p;
    logic [31:0] v;
    repeat (count) begin
      rand_request(c, p, v);
      send_request(c, p, v);
    end
  endtask

  // Hand-picked requests at the default size: empty table, wrapping adds,
  // ignored adds at index zero and above the size, unused code, clear.
  task automatic test_directed_cases();
    send_request(CMD_QUERY, 11'd0, 32'h0);
    send_request(CMD_QUERY, 11'd1024, 32'hffff_ffff);
    send_request(CMD_ADD, 11'd1, 32'h7fff_ffff);
    send_request(CMD_ADD, 11'd1, 32'h0000_0001);
    send_request(CMD_ADD, 11'd1024, 32'h8000_0000);
    send_request(CMD_ADD, 11'd0, 32'h0000_0005);
    send_request(CMD_ADD, 11'd1025, 32'h0000_0009);
    send_request(CMD_ADD, 11'd2047, 32'hffff_ffff);
    send_request(CMD_ADD, 11'd683, 32'h5555_5555);
    send_request(CMD_ADD, 11'd1023, 32'haaaa_aaaa);
    send_request(CMD_UNUSED, 11'd2047, 32'hffff_ffff);
    send_request(CMD_QUERY, 11'd1, 32'h0);
    send_request(CMD_QUERY, 11'd682, 32'h0);
    send_request(CMD_QUERY, 11'd683, 32'h0);
    send_request(CMD_QUERY, 11'd1023, 32'h0);
    send_request(CMD_QUERY, 11'd1024, 32'h0);
    send_request(CMD_QUERY, 11'd1025, 32'h0);
    send_request(CMD_QUERY, 11'd2047, 32'h0);
    send_request(CMD_CLEAR, 11'd5, 32'h1234_5678);
    send_request(CMD_QUERY, 11'd1024, 32'h0);
    send_request(CMD_QUERY, 11'd683, 32'h0);
  endtask

  // Walks the size register through its extremes: a single cell, zero (all
  // adds dropped), all ones (capped at the table), two cells, a random size, full size.
  task automatic test_size_settings();
    logic [SIZE_W-1:0] sizes [6];
    sizes[0] = 11'd1;
    sizes[1] = 11'd0;
    sizes[2] = 11'd2047;
    sizes[3] = 11'd2;
    sizes[4] = SIZE_W'($urandom_range(1023, 3));
    sizes[5] = 11'd1024;
    foreach (sizes[i]) begin
      drain_and_settle();
      write_size(sizes[i]);
      test_random_traffic(30);
    end
  endtask

  task automatic test_no_idle_burst();
    idle_on = 1'b0;
    test_random_traffic(150);
    idle_on = 1'b1;
  endtask

  // The receiver holds off for a long stretch while requests keep coming, so
  // the output register fills and the block must stall its input.
  task automatic test_output_backpressure();
    int unsigned k;
    idle_on = 1'b0;
    stop_sending();
    @(posedge clk_i);
    hold_left = 400;
    for (k = 0; k < 40; k++) begin
      if (k % 3 == 2) send_request(CMD_ADD, POS_W'($urandom_range(1024, 1)), $urandom());
      else send_request(CMD_QUERY, POS_W'($urandom_range(1024, 0)), 32'h0);
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    cmd_i       = CMD_QUERY;
    position_i  = '0;
    add_value_i = '0;
    out_stall_i = 1'b0;
    size_reg    = 11'd1024;
    foreach (tree_cells[i]) tree_cells[i] = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // The block runs its clearing pass first; the sender simply waits on stall.
    test_directed_cases();
    test_size_settings();
    test_random_traffic(760);
    test_no_idle_burst();
    test_output_backpressure();

    drain_and_settle();
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
